// File: design/ksl_pkg.sv
`default_nettype none

package ksl_pkg;

    // Field widths fixed by the request format.
    localparam int unsigned OP_W   = 2;
    localparam int unsigned KEY_W  = 63;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned STAT_W = 2;

    // Default number of slots in the table.
    localparam int unsigned SLOT_COUNT_DEF = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    // Request held for the resolve cycle.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] wdata;
    } req_t;

    // Priority information passed from one cell to the next.
    typedef struct packed {
        logic              hit_seen;
        logic              free_seen;
        logic [DATA_W-1:0] rdata;
    } chain_t;

endpackage

`default_nettype wire

// File: design/ksl_cell.sv
`default_nettype none

module ksl_cell
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cap,
    input  wire logic [ksl_pkg::KEY_W-1:0]    cmp_key,
    input  wire logic                         act,
    input  wire ksl_pkg::req_t                req,
    input  wire logic                         hit_any,
    input  wire ksl_pkg::chain_t              chain_in,
    output ksl_pkg::chain_t                   chain_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [ksl_pkg::KEY_W-1:0]     key_reg;
    logic [ksl_pkg::KEY_W-1:0]     key_next;
    logic [ksl_pkg::DATA_W-1:0]    value_reg;
    logic [ksl_pkg::DATA_W-1:0]    value_next;
    logic                          match_reg;
    logic                          match_next;
    logic                          first_hit;
    logic                          first_free;

    // The key compare is registered when an item is accepted.
    assign match_next = cap ? (valid_reg && (key_reg == cmp_key)) : match_reg;

    // This cell is chosen when no cell nearer the head has claimed the request.
    assign first_hit  = match_reg && !chain_in.hit_seen;
    assign first_free = !valid_reg && !chain_in.free_seen;

    // Pass the priority marks and the read data on to the next cell.
    always_comb
    begin
        chain_out.hit_seen  = chain_in.hit_seen | match_reg;
        chain_out.free_seen = chain_in.free_seen | !valid_reg;
        chain_out.rdata     = chain_in.rdata | (first_hit ? value_reg : '0);
    end

    // Slot update in the resolve cycle.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (act)
        begin
            case (req.op)
                ksl_pkg::OP_ALLOC:
                begin
                    if (!hit_any && first_free)
                    begin
                        valid_next = 1'b1;
                        key_next   = req.key;
                        value_next = '0;
                    end
                end
                ksl_pkg::OP_SET:
                begin
                    if (first_hit)
                    begin
                        value_next = req.wdata;
                    end
                end
                ksl_pkg::OP_FREE:
                begin
                    if (first_hit)
                    begin
                        valid_next = 1'b0;
                        value_next = '0;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Valid mark and match flag are control state and are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // Key and data word are payload.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: design/keyed_slot_table_top.sv
// Channel   Handshake               Fields
// request   start, busy             operation, owner_key, write_value
// result    done (one-cycle strobe) read_value, status
//
// For each item, the key is compared in every slot cell at the accepting
// edge, and in the next cycle the lowest hit or free slot is found along the
// cell chain, the slot is updated and the result is registered.
// The next item may be accepted in the cycle in which done is high.
// Reset clears every valid mark at once; no clearing pass is needed.
// The receiver cannot stall: done is high for one cycle only.
`default_nettype none

module keyed_slot_table_top
#(
    parameter int unsigned SLOT_COUNT = ksl_pkg::SLOT_COUNT_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ksl_pkg::OP_W-1:0]       operation,
    input  wire logic [ksl_pkg::KEY_W-1:0]      owner_key,
    input  wire logic [ksl_pkg::DATA_W-1:0]     write_value,
    output logic                                done,
    output logic [ksl_pkg::DATA_W-1:0]          read_value,
    output logic [ksl_pkg::STAT_W-1:0]          status
);

    logic                          accept;
    logic                          busy_reg;
    logic                          done_reg;
    ksl_pkg::req_t                 req_reg;
    ksl_pkg::req_t                 req_next;
    logic [ksl_pkg::DATA_W-1:0]    rdata_reg;
    logic [ksl_pkg::DATA_W-1:0]    rdata_next;
    logic [ksl_pkg::STAT_W-1:0]    status_reg;
    logic [ksl_pkg::STAT_W-1:0]    status_next;
    logic                          hit_any;
    logic                          free_any;
    ksl_pkg::chain_t               chain [0:SLOT_COUNT];

    assign accept = start && !busy_reg;

    // Hold the request for the resolve cycle.
    always_comb
    begin
        req_next = req_reg;
        if (accept)
        begin
            req_next.op    = operation;
            req_next.key   = owner_key;
            req_next.wdata = write_value;
        end
    end

    // Head of the chain: nothing claimed yet.
    always_comb
    begin
        chain[0].hit_seen  = 1'b0;
        chain[0].free_seen = 1'b0;
        chain[0].rdata     = '0;
    end

    // One cell for each slot.
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        ksl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cap       (accept),
            .cmp_key   (owner_key),
            .act       (busy_reg),
            .req       (req_reg),
            .hit_any   (hit_any),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    assign hit_any  = chain[SLOT_COUNT].hit_seen;
    assign free_any = chain[SLOT_COUNT].free_seen;

    // Result of the resolve cycle.
    always_comb
    begin
        rdata_next  = '0;
        status_next = ksl_pkg::ST_OK;
        case (req_reg.op)
            ksl_pkg::OP_ALLOC:
            begin
                if (hit_any)
                begin
                    status_next = ksl_pkg::ST_PRESENT;
                end
                else if (!free_any)
                begin
                    status_next = ksl_pkg::ST_FULL;
                end
            end
            ksl_pkg::OP_GET:
            begin
                if (hit_any)
                begin
                    rdata_next = chain[SLOT_COUNT].rdata;
                end
                else
                begin
                    status_next = ksl_pkg::ST_MISSING;
                end
            end
            default:
            begin
                if (!hit_any)
                begin
                    status_next = ksl_pkg::ST_MISSING;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
        end
    end

    // Request and result registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (busy_reg)
        begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign read_value = rdata_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire
